// ===== src/circle_rotated_rect_hit_test_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CIRCLE_ROTATED_RECT_HIT_TEST_DEFINES_SVH
`define CIRCLE_ROTATED_RECT_HIT_TEST_DEFINES_SVH

// Assert that a property holds at every clock edge outside reset.
`define CRRH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a property holds at every clock edge, also during reset.
`define CRRH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/crrh_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle versus rotated rectangle package
// Shared widths, CORDIC constants and types of the hit test block.
// ----------------------------------------------------------------------------
package crrh_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int SIZE_WIDTH      = 14;
    localparam int ANGLE_WIDTH     = 13;
    localparam int RADIUS_WIDTH    = 14;
    localparam int FRAC_BITS       = 28;
    localparam int TRIG_WIDTH      = 31;
    localparam int Z_WIDTH         = 29;
    localparam int D_WIDTH         = COORD_WIDTH + 3;
    localparam int PROD_WIDTH      = D_WIDTH + TRIG_WIDTH;
    localparam int L_WIDTH         = PROD_WIDTH - FRAC_BITS + 1;
    localparam int E_WIDTH         = L_WIDTH;
    localparam int SQ_WIDTH        = 2 * (RADIUS_WIDTH + 1) + 1;
    localparam int CORDIC_K        = 163008219;
    localparam int FULL_TURN       = 5760;
    localparam int QUARTER_TURN    = 1440;

    typedef logic signed [TRIG_WIDTH-1:0] t_trig;
    typedef logic signed [Z_WIDTH-1:0]    t_angle_acc;
    typedef logic signed [D_WIDTH-1:0]    t_delta;

    // Quadrant of the rotation.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Data that travels with a query through the CORDIC cells.
    typedef struct packed {
        t_delta                dx2;
        t_delta                dy2;
        logic [SIZE_WIDTH-1:0] w;
        logic [SIZE_WIDTH-1:0] h;
        t_quad                 quad;
    } t_query;

    // State carried from one CORDIC cell to the next.
    typedef struct packed {
        logic       valid;
        t_trig      x;
        t_trig      y;
        t_angle_acc z;
        t_query     q;
    } t_cell;

    function automatic t_angle_acc atan_entry(input int idx);
        t_angle_acc v;
        case (idx)
            0:  v = Z_WIDTH'(47185920);
            1:  v = Z_WIDTH'(27855475);
            2:  v = Z_WIDTH'(14718068);
            3:  v = Z_WIDTH'(7471121);
            4:  v = Z_WIDTH'(3750058);
            5:  v = Z_WIDTH'(1876857);
            6:  v = Z_WIDTH'(938658);
            7:  v = Z_WIDTH'(469357);
            8:  v = Z_WIDTH'(234682);
            9:  v = Z_WIDTH'(117342);
            10: v = Z_WIDTH'(58671);
            11: v = Z_WIDTH'(29335);
            12: v = Z_WIDTH'(14668);
            13: v = Z_WIDTH'(7334);
            14: v = Z_WIDTH'(3667);
            15: v = Z_WIDTH'(1833);
            16: v = Z_WIDTH'(917);
            17: v = Z_WIDTH'(458);
            18: v = Z_WIDTH'(229);
            19: v = Z_WIDTH'(115);
            20: v = Z_WIDTH'(57);
            21: v = Z_WIDTH'(29);
            22: v = Z_WIDTH'(14);
            23: v = Z_WIDTH'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/crrh_if.sv =====
// ----------------------------------------------------------------------------
// Hit test channels
// Valid/ready channels for queries, results and the radius register.
// ----------------------------------------------------------------------------
interface crrh_query_if import crrh_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] circle_x;
    logic signed [COORD_WIDTH-1:0] circle_y;
    logic signed [COORD_WIDTH-1:0] rect_left;
    logic signed [COORD_WIDTH-1:0] rect_top;
    logic [SIZE_WIDTH-1:0]         rect_width;
    logic [SIZE_WIDTH-1:0]         rect_height;
    logic [ANGLE_WIDTH-1:0]        rect_angle;

    modport source (output valid, circle_x, circle_y, rect_left, rect_top,
                    rect_width, rect_height, rect_angle, input ready);
    modport sink (input valid, circle_x, circle_y, rect_left, rect_top,
                  rect_width, rect_height, rect_angle, output ready);
endinterface

interface crrh_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

interface crrh_cfg_if import crrh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RADIUS_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/crrh_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One rotation step with a fixed shift, registered toward the next cell.
// ----------------------------------------------------------------------------
module crrh_cordic_cell import crrh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [4:0]             i_shift,
    input  t_angle_acc             i_atan,
    input  t_cell                  i_cell,
    output t_cell                  o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    t_trig xs;
    t_trig ys;

    always_comb begin
        xs = i_cell.x >>> i_shift;
        ys = i_cell.y >>> i_shift;
        n_cell = i_cell;
        if (!i_cell.z[Z_WIDTH-1]) begin
            n_cell.x = i_cell.x - ys;
            n_cell.y = i_cell.y + xs;
            n_cell.z = i_cell.z - i_atan;
        end else begin
            n_cell.x = i_cell.x + ys;
            n_cell.y = i_cell.y - xs;
            n_cell.z = i_cell.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.x <= n_cell.x;
            r_cell.y <= n_cell.y;
            r_cell.z <= n_cell.z;
            r_cell.q <= n_cell.q;
        end
    end

    assign o_cell = r_cell;
endmodule

// ===== src/crrh_back_end.sv =====
// ----------------------------------------------------------------------------
// Frame transform and distance test
// Rotates the offset into the rectangle frame, clamps and compares.
// ----------------------------------------------------------------------------
module crrh_back_end import crrh_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [RADIUS_WIDTH-1:0] i_radius,
    input  t_cell                   i_cell,
    output logic                    o_valid,
    output logic                    o_hit
);
    localparam int STAGES = 4;

    t_trig c;
    t_trig s;
    logic signed [PROD_WIDTH-1:0] r_dxc, r_dys, r_dyc, r_dxs;
    logic [SIZE_WIDTH-1:0]        r_w1, r_h1, r_w2, r_h2;
    logic signed [L_WIDTH-1:0]    r_lx, r_ly;
    logic [E_WIDTH-1:0]           r_ex, r_ey;
    logic [STAGES-1:0]            r_v;
    logic                         r_hit;
    logic signed [PROD_WIDTH:0]   sx, sy;
    logic [L_WIDTH-1:0]           ax, ay;
    logic signed [L_WIDTH:0]      exd, eyd;
    logic [RADIUS_WIDTH:0]        lim;
    logic [SQ_WIDTH-1:0]          sum;

    always_comb begin
        case (i_cell.q.quad)
            QUAD_0: begin c = i_cell.x;  s = i_cell.y;  end
            QUAD_1: begin c = -i_cell.y; s = i_cell.x;  end
            QUAD_2: begin c = -i_cell.x; s = -i_cell.y; end
            QUAD_3: begin c = i_cell.y;  s = -i_cell.x; end
            default: begin c = i_cell.x; s = i_cell.y;  end
        endcase
    end

    always_comb begin
        sx = (PROD_WIDTH+1)'(r_dxc) + (PROD_WIDTH+1)'(r_dys)
             + (PROD_WIDTH+1)'(64'sd1 <<< (FRAC_BITS-1));
        sy = (PROD_WIDTH+1)'(r_dyc) - (PROD_WIDTH+1)'(r_dxs)
             + (PROD_WIDTH+1)'(64'sd1 <<< (FRAC_BITS-1));
        ax = r_lx[L_WIDTH-1] ? L_WIDTH'(-r_lx) : L_WIDTH'(r_lx);
        ay = r_ly[L_WIDTH-1] ? L_WIDTH'(-r_ly) : L_WIDTH'(r_ly);
        exd = $signed({1'b0, ax}) - $signed({1'b0, (L_WIDTH)'(r_w2)});
        eyd = $signed({1'b0, ay}) - $signed({1'b0, (L_WIDTH)'(r_h2)});
        lim = {i_radius, 1'b0};
        sum = SQ_WIDTH'(r_ex) * SQ_WIDTH'(r_ex) + SQ_WIDTH'(r_ey) * SQ_WIDTH'(r_ey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_cell.valid};
        end
        if (i_en) begin
            r_dxc <= PROD_WIDTH'(i_cell.q.dx2 * c);
            r_dys <= PROD_WIDTH'(i_cell.q.dy2 * s);
            r_dyc <= PROD_WIDTH'(i_cell.q.dy2 * c);
            r_dxs <= PROD_WIDTH'(i_cell.q.dx2 * s);
            r_w1  <= i_cell.q.w;
            r_h1  <= i_cell.q.h;
            r_lx  <= L_WIDTH'(sx >>> FRAC_BITS);
            r_ly  <= L_WIDTH'(sy >>> FRAC_BITS);
            r_w2  <= r_w1;
            r_h2  <= r_h1;
            r_ex  <= exd[L_WIDTH] ? '0 : E_WIDTH'(exd);
            r_ey  <= eyd[L_WIDTH] ? '0 : E_WIDTH'(eyd);
            r_hit <= (r_ex < E_WIDTH'(lim)) && (r_ey < E_WIDTH'(lim))
                     && (sum < SQ_WIDTH'(lim) * SQ_WIDTH'(lim));
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_hit   = r_hit;
endmodule

// ===== src/circle_rotated_rect_hit_test.sv =====
// ----------------------------------------------------------------------------
// Circle versus rotated rectangle hit test
// Answers whether a circle of the configured radius overlaps a rectangle
// rotated about its center.
//
// Channels: i_query carries one query per beat, o_result one hit flag per
// beat, i_cfg writes the radius (1/16 pixel, reset 2400). Write the radius
// only while no query is in flight.
// Stages: the input register, TRIG_ITERATIONS CORDIC cells (at most 24) and
// the frame transform and compare.
// Throughput: one query per cycle while the result is not stalled; every cell
// of the CORDIC chain holds one query and hands it on each enabled cycle.
// A stalled receiver freezes the whole pipeline; the input is still taken
// while the last stage is empty or being drained.
// Reset empties the pipeline and restores the radius.
// ----------------------------------------------------------------------------
module circle_rotated_rect_hit_test import crrh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    crrh_query_if.sink         i_query,
    crrh_result_if.source      o_result,
    crrh_cfg_if.sink           i_cfg
);
    localparam int NCELL = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

    logic [RADIUS_WIDTH-1:0] r_radius;
    t_cell                   r_head;
    t_cell                   n_head;
    t_cell                   chain [NCELL+1];
    logic                    en;
    logic                    be_valid;
    logic                    be_hit;
    logic [ANGLE_WIDTH-1:0]  ang;
    logic [ANGLE_WIDTH-1:0]  rem;
    t_quad                   quad;

    assign en = !o_result.valid || o_result.ready;
    assign i_query.ready = en;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_WIDTH'(2400);
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.data;
        end
    end

    always_comb begin
        ang = (i_query.rect_angle >= ANGLE_WIDTH'(FULL_TURN))
              ? i_query.rect_angle - ANGLE_WIDTH'(FULL_TURN) : i_query.rect_angle;
        if (ang >= ANGLE_WIDTH'(3 * QUARTER_TURN)) begin
            quad = QUAD_3; rem = ang - ANGLE_WIDTH'(3 * QUARTER_TURN);
        end else if (ang >= ANGLE_WIDTH'(2 * QUARTER_TURN)) begin
            quad = QUAD_2; rem = ang - ANGLE_WIDTH'(2 * QUARTER_TURN);
        end else if (ang >= ANGLE_WIDTH'(QUARTER_TURN)) begin
            quad = QUAD_1; rem = ang - ANGLE_WIDTH'(QUARTER_TURN);
        end else begin
            quad = QUAD_0; rem = ang;
        end
        n_head.valid  = i_query.valid;
        n_head.x      = TRIG_WIDTH'(CORDIC_K);
        n_head.y      = '0;
        n_head.z      = Z_WIDTH'({rem, 16'b0});
        n_head.q.dx2  = D_WIDTH'(2 * D_WIDTH'(i_query.circle_x))
                      - D_WIDTH'(2 * D_WIDTH'(i_query.rect_left))
                      - D_WIDTH'({1'b0, i_query.rect_width});
        n_head.q.dy2  = D_WIDTH'(2 * D_WIDTH'(i_query.circle_y))
                      - D_WIDTH'(2 * D_WIDTH'(i_query.rect_top))
                      - D_WIDTH'({1'b0, i_query.rect_height});
        n_head.q.w    = i_query.rect_width;
        n_head.q.h    = i_query.rect_height;
        n_head.q.quad = quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (en) begin
            r_head.valid <= n_head.valid;
        end
        if (en) begin
            r_head.x <= n_head.x;
            r_head.y <= n_head.y;
            r_head.z <= n_head.z;
            r_head.q <= n_head.q;
        end
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        crrh_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (5'(g)),
            .i_atan  (atan_entry(g)),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    crrh_back_end u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_radius (r_radius),
        .i_cell   (chain[NCELL]),
        .o_valid  (be_valid),
        .o_hit    (be_hit)
    );

    assign o_result.valid = be_valid;
    assign o_result.hit   = be_hit;
endmodule

// ===== src/crrh_checker.sv =====
// ----------------------------------------------------------------------------
// Hit test port checker
// Watches the top level ports and checks handshake and pipeline behavior.
// ----------------------------------------------------------------------------
`include "circle_rotated_rect_hit_test_defines.svh"

module crrh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic q_ready,
    input logic r_valid,
    input logic r_ready,
    input logic r_hit,
    input logic c_ready
);
    `CRRH_ASSERT(a_hold, i_clk, i_rst_n, r_valid && !r_ready |=> r_valid && $stable(r_hit), "result beat dropped while stalled")
    `CRRH_ASSERT(a_ready, i_clk, i_rst_n, q_ready == (!r_valid || r_ready), "query ready does not follow result stall")
    `CRRH_ASSERT(a_cfg, i_clk, i_rst_n, c_ready, "radius port not ready")
    `CRRH_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !r_valid, "result valid after reset")
endmodule

bind circle_rotated_rect_hit_test crrh_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .q_ready (i_query.ready),
    .r_valid (o_result.valid),
    .r_ready (o_result.ready),
    .r_hit   (o_result.hit),
    .c_ready (i_cfg.ready)
);
